// File: src/ptns_pkg.sv
package ptns_pkg;

    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;

    // Item kinds on the input tuser.
    localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DUP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic load_query;
        logic add_write;
        logic scan_start;
        logic issue;
        logic load_result;
    } ctrl_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last_issue;
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

// File: src/ptns_ram.sv
module ptns_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/ptns_ctrl.sv
module ptns_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ptns_pkg::KIND_W-1:0]     kind,
    input  ptns_pkg::dp_status_t            status,
    output ptns_pkg::ctrl_cmd_t             cmd
);

    import ptns_pkg::*;

    typedef enum logic [3:0] {
        STATE_IDLE  = 4'b0001,
        STATE_SCAN  = 4'b0010,
        STATE_DRAIN = 4'b0100,
        STATE_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   is_query;

    assign accept   = s_tvalid && (state_reg == STATE_IDLE);
    assign is_query = (kind == KIND_DUP) || (kind == KIND_NEAR);

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            STATE_IDLE: begin
                s_tready       = 1'b1;
                cmd.load_query = accept;
                cmd.add_write  = accept && (kind == KIND_ADD);
                cmd.scan_start = accept && is_query && !status.count_zero;
                if (accept) begin
                    state_next = cmd.scan_start ? STATE_SCAN : STATE_DONE;
                end
            end
            STATE_SCAN: begin
                cmd.issue = 1'b1;
                if (status.last_issue) begin
                    state_next = STATE_DRAIN;
                end
            end
            STATE_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = STATE_DONE;
                end
            end
            STATE_DONE: begin
                if (status.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = STATE_IDLE;
                end
            end
            default: begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/ptns_dp.sv
module ptns_dp #(
    parameter int TABLE_SIZE = 256,
    parameter int COORD_BITS = 16,
    parameter int IN_DATA_W  = 32,
    parameter int OUT_DATA_W = 48
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ptns_pkg::ctrl_cmd_t                 cmd,
    output ptns_pkg::dp_status_t                status,
    input  logic [IN_DATA_W-1:0]                s_tdata,
    input  logic [ptns_pkg::KIND_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [OUT_DATA_W-1:0]               m_tdata,
    output logic [ptns_pkg::STATUS_W:0]         m_tuser
);

    import ptns_pkg::*;

    localparam int CB     = COORD_BITS;
    localparam int AW     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int SQ_W   = 2 * CB;
    localparam int DIST_W = 2 * CB + 1;

    // Query and table bookkeeping.
    logic [KIND_W-1:0]  kind_reg;
    logic signed [CB-1:0] qx_reg, qy_reg;
    logic               drop_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   scan_addr_reg;
    logic               full;
    logic               found_reg;

    // Scan pipeline: read, difference, square, sum, compare.
    logic               v_rd_reg, first_rd_reg;
    logic               va_reg, first_a_reg, tie_a_reg;
    logic [CB-1:0]      dx_a_reg, dy_a_reg;
    logic signed [CB-1:0] px_a_reg, py_a_reg;
    logic               vb_reg, first_b_reg, tie_b_reg;
    logic [SQ_W-1:0]    sqx_b_reg, sqy_b_reg;
    logic signed [CB-1:0] px_b_reg, py_b_reg;
    logic               vc_reg, first_c_reg, tie_c_reg;
    logic [DIST_W-1:0]  dist_c_reg;
    logic signed [CB-1:0] px_c_reg, py_c_reg;

    logic [DIST_W-1:0]  best_dist_reg;
    logic signed [CB-1:0] best_x_reg, best_y_reg;

    logic [2*CB-1:0]    rdata;
    logic signed [CB-1:0] px, py, in_x, in_y;
    logic signed [CB:0] diff_x, diff_y;
    logic               take;

    // Output register.
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W:0]     m_tuser_reg;
    logic                  res_found;
    logic signed [CB-1:0]  res_x, res_y;
    logic [STATUS_W-1:0]   res_status;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign in_x = $signed(s_tdata[CB-1:0]);
    assign in_y = $signed(s_tdata[2*CB-1:CB]);
    assign full = (count_reg == CNT_W'(TABLE_SIZE));

    ptns_ram #(
        .WIDTH  (2 * CB),
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.add_write && !full),
        .waddr (count_reg[AW-1:0]),
        .wdata (s_tdata[2*CB-1:0]),
        .raddr (scan_addr_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign px     = $signed(rdata[CB-1:0]);
    assign py     = $signed(rdata[2*CB-1:CB]);
    assign diff_x = {px[CB-1], px} - {qx_reg[CB-1], qx_reg};
    assign diff_y = {py[CB-1], py} - {qy_reg[CB-1], qy_reg};

    // The first entry always wins; on equal distance the tie rule decides.
    assign take = first_c_reg || (dist_c_reg < best_dist_reg) ||
                  ((dist_c_reg == best_dist_reg) && tie_c_reg);

    assign status.count_zero = (count_reg == '0);
    assign status.last_issue = (scan_addr_reg == count_reg - CNT_W'(1));
    assign status.pipe_busy  = v_rd_reg || va_reg || vb_reg || vc_reg;
    assign status.out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            v_rd_reg     <= 1'b0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.add_write && !full) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            v_rd_reg <= cmd.issue;
            va_reg   <= v_rd_reg;
            vb_reg   <= va_reg;
            vc_reg   <= vb_reg;
            if (cmd.load_result) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            kind_reg <= s_tuser;
            qx_reg   <= in_x;
            qy_reg   <= in_y;
            drop_reg <= cmd.add_write && full;
        end
        if (cmd.scan_start) begin
            scan_addr_reg <= '0;
        end else if (cmd.issue) begin
            scan_addr_reg <= scan_addr_reg + CNT_W'(1);
        end
        first_rd_reg <= (scan_addr_reg == '0);

        // Difference stage; the exact match for duplicate queries is taken here.
        first_a_reg <= first_rd_reg;
        dx_a_reg    <= diff_x[CB] ? CB'(-diff_x) : diff_x[CB-1:0];
        dy_a_reg    <= diff_y[CB] ? CB'(-diff_y) : diff_y[CB-1:0];
        tie_a_reg   <= (px > qx_reg) || ((px == qx_reg) && (py > qy_reg));
        px_a_reg    <= px;
        py_a_reg    <= py;
        if (cmd.scan_start) begin
            found_reg <= 1'b0;
        end else if (v_rd_reg && (px == qx_reg) && (py == qy_reg)) begin
            found_reg <= 1'b1;
        end

        first_b_reg <= first_a_reg;
        tie_b_reg   <= tie_a_reg;
        sqx_b_reg   <= dx_a_reg * dx_a_reg;
        sqy_b_reg   <= dy_a_reg * dy_a_reg;
        px_b_reg    <= px_a_reg;
        py_b_reg    <= py_a_reg;

        first_c_reg <= first_b_reg;
        tie_c_reg   <= tie_b_reg;
        dist_c_reg  <= DIST_W'(sqx_b_reg) + DIST_W'(sqy_b_reg);
        px_c_reg    <= px_b_reg;
        py_c_reg    <= py_b_reg;

        if (vc_reg && take) begin
            best_dist_reg <= dist_c_reg;
            best_x_reg    <= px_c_reg;
            best_y_reg    <= py_c_reg;
        end

        if (cmd.load_result) begin
            m_tdata_reg <= OUT_DATA_W'({count_ext[COUNT_OUT_W-1:0], res_y, res_x});
            m_tuser_reg <= {res_status, res_found};
        end
    end

    always_comb begin
        res_found  = 1'b0;
        res_x      = '0;
        res_y      = '0;
        res_status = STATUS_OK;
        count_ext  = {{COUNT_OUT_W{1'b0}}, count_reg};
        case (kind_reg)
            KIND_ADD: begin
                res_status = drop_reg ? STATUS_FULL : STATUS_OK;
            end
            KIND_DUP: begin
                res_found = !status.count_zero && found_reg;
            end
            KIND_NEAR: begin
                if (status.count_zero) begin
                    res_status = STATUS_EMPTY;
                end else begin
                    res_found = 1'b1;
                    res_x     = best_x_reg;
                    res_y     = best_y_reg;
                end
            end
            default: begin
                res_found = 1'b0;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: src/point_table_nearest_search.sv
// A duplicate or nearest query over a non-empty table scans every stored point before its
// word is loaded; an add, a query on an empty table or an unused kind is answered without a scan.
// A new item is taken only after the previous result word has been loaded into the output register.
// The scan reads one entry per cycle from the single point memory.
// Reset (aresetn low, synchronous) empties the table and clears the controller and output.
module point_table_nearest_search #(
    parameter int TABLE_SIZE = 256,
    parameter int COORD_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // coord_x, coord_y
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    // kind
    input  logic [ptns_pkg::KIND_W-1:0]         s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // near_x, near_y, stored_count
    output logic [((2*COORD_BITS+16)/8)*8-1:0]  m_tdata,
    // found, status
    output logic [ptns_pkg::STATUS_W:0]         m_tuser
);

    import ptns_pkg::*;

    localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * COORD_BITS + 16) / 8) * 8;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    ptns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    ptns_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .COORD_BITS (COORD_BITS),
        .IN_DATA_W  (IN_DATA_W),
        .OUT_DATA_W (OUT_DATA_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef ASSERT_OFF
    // A finished result never overwrites a word that is still waiting.
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> status.out_free)
        else $error("result loaded while output word still pending");

    // The scan only runs over a table that holds at least one point.
    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !status.count_zero)
        else $error("scan issued on an empty table");

    // One item is worked on at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new item accepted while previous still in progress");

    // The pipeline is empty whenever a new item is taken.
    a_idle_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_query |-> !status.pipe_busy)
        else $error("item accepted with scan pipeline busy");
`endif

endmodule
